[hw/rtl/geohash_encoder_top_macros.svh]
// Assertion macros shared by the geohash encoder modules.
// Both expect clk_i in the enclosing module; GHE_ASSERT also expects rst_ni.
`ifndef GEOHASH_ENCODER_TOP_MACROS_SVH
`define GEOHASH_ENCODER_TOP_MACROS_SVH

// Checked outside reset only.
`define GHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every edge, reset included.
`define GHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

[hw/rtl/ghe_pkg.sv]
`timescale 1ns / 1ps
package ghe_pkg;

  // Field widths
  localparam int COORD_W  = 32;
  localparam int PREC_W   = 4;
  localparam int SYM_W    = 7;
  localparam int CFG_IDX_W = 2;

  // Encoding constants
  localparam int MAX_CHARS       = 12;
  localparam int COORD_FRAC_BITS = 23;
  localparam int EXTRA_BITS      = 8;
  localparam int SYM_BITS        = 5;

  // Bisection datapath: coordinate scaled by 2^EXTRA_BITS
  localparam int CALC_W    = COORD_W + EXTRA_BITS;
  localparam int NSTEP_MAX = (MAX_CHARS * SYM_BITS + 1) / 2;
  localparam int BITS_W    = 2 * NSTEP_MAX;
  localparam int STEP_W    = $clog2(NSTEP_MAX + 1);
  localparam int NBITS_W   = $clog2(BITS_W + 1) + 1;

  // Initial interval bounds in the scaled format
  localparam logic signed [CALC_W-1:0] LON_HI0 =
    CALC_W'(64'sd180 <<< (COORD_FRAC_BITS + EXTRA_BITS));
  localparam logic signed [CALC_W-1:0] LAT_HI0 =
    CALC_W'(64'sd90 <<< (COORD_FRAC_BITS + EXTRA_BITS));
  localparam logic signed [CALC_W-1:0] LON_LO0 = -LON_HI0;
  localparam logic signed [CALC_W-1:0] LAT_LO0 = -LAT_HI0;

  // Reset values of the bound registers
  localparam logic signed [COORD_W-1:0] LAT_MAX_RST =
    COORD_W'(64'sd90 <<< COORD_FRAC_BITS);
  localparam logic signed [COORD_W-1:0] LAT_MIN_RST = -LAT_MAX_RST;
  localparam logic signed [COORD_W-1:0] LON_MAX_RST =
    COORD_W'(64'sd180 <<< COORD_FRAC_BITS);
  localparam logic signed [COORD_W-1:0] LON_MIN_RST = -LON_MAX_RST;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_MAX = 2'd0,
    CFG_LAT_MIN = 2'd1,
    CFG_LON_MAX = 2'd2,
    CFG_LON_MIN = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    cfg_idx_e            idx;
    logic [COORD_W-1:0]  data;
  } cfg_wr_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [COORD_W-1:0] lat;
    logic signed [COORD_W-1:0] lon;
    logic [PREC_W-1:0]         prec;
    logic                      bad;
  } job_t;

  // Base32 geohash alphabet, ASCII
  localparam logic [SYM_W-1:0] GEO_ALPHABET [32] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
    7'h68, 7'h6A, 7'h6B, 7'h6D, 7'h6E, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A
  };

endpackage

[hw/rtl/ghe_in_if.sv]
`timescale 1ns / 1ps
interface ghe_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [ghe_pkg::COORD_W-1:0] latitude;
  logic signed [ghe_pkg::COORD_W-1:0] longitude;
  logic [ghe_pkg::PREC_W-1:0]         precision;

  modport source (output valid, latitude, longitude, precision, input ready);
  modport sink   (input valid, latitude, longitude, precision, output ready);
endinterface

[hw/rtl/ghe_out_if.sv]
`timescale 1ns / 1ps
interface ghe_out_if;
  logic                      valid;
  logic                      ready;
  logic [ghe_pkg::SYM_W-1:0] symbol;
  logic                      last;
  logic                      bad_coordinate;

  modport source (output valid, symbol, last, bad_coordinate, input ready);
  modport sink   (input valid, symbol, last, bad_coordinate, output ready);
endinterface

[hw/rtl/ghe_front.sv]
`timescale 1ns / 1ps
module ghe_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  ghe_in_if.sink           item_i,
  input  ghe_pkg::cfg_wr_t cfg_i,
  output ghe_pkg::job_t    job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);

  logic signed [ghe_pkg::COORD_W-1:0] lat_max_q, lat_min_q, lon_max_q, lon_min_q;
  logic                               out_of_bounds;
  logic                               prec_bad;

  // Bound registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_max_q <= ghe_pkg::LAT_MAX_RST;
      lat_min_q <= ghe_pkg::LAT_MIN_RST;
      lon_max_q <= ghe_pkg::LON_MAX_RST;
      lon_min_q <= ghe_pkg::LON_MIN_RST;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        ghe_pkg::CFG_LAT_MAX: lat_max_q <= cfg_i.data;
        ghe_pkg::CFG_LAT_MIN: lat_min_q <= cfg_i.data;
        ghe_pkg::CFG_LON_MAX: lon_max_q <= cfg_i.data;
        ghe_pkg::CFG_LON_MIN: lon_min_q <= cfg_i.data;
      endcase
    end
  end

  // Classify: bounds check and precision clamp
  assign out_of_bounds = (item_i.latitude > lat_max_q) || (item_i.latitude < lat_min_q) ||
                         (item_i.longitude > lon_max_q) || (item_i.longitude < lon_min_q);
  assign prec_bad = (item_i.precision == '0) ||
                    (item_i.precision > ghe_pkg::PREC_W'(ghe_pkg::MAX_CHARS));

  always_comb begin
    job_o.lat  = item_i.latitude;
    job_o.lon  = item_i.longitude;
    job_o.prec = prec_bad ? ghe_pkg::PREC_W'(ghe_pkg::MAX_CHARS) : item_i.precision;
    job_o.bad  = out_of_bounds;
  end

  // Transfer straight into the queue
  assign job_valid_o  = item_i.valid;
  assign item_i.ready = job_ready_i;

endmodule

[hw/rtl/ghe_fifo.sv]
`timescale 1ns / 1ps
`include "geohash_encoder_top_macros.svh"
module ghe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ghe_pkg::job_t push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output ghe_pkg::job_t pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);

  ghe_pkg::job_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `GHE_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2, "queue count beyond depth")
  `GHE_ASSERT(a_empty_pass, (cnt_q == 2'd0) && push |=> pop_valid_o && (pop_data_o == $past(push_data_i)), "item pushed into empty queue not at head")
  `GHE_ASSERT(a_ptr_match, (cnt_q == 2'd0) || (cnt_q == 2'd2) |-> wr_ptr_q == rd_ptr_q, "pointers disagree with count")

endmodule

[hw/rtl/ghe_back.sv]
`timescale 1ns / 1ps
`include "geohash_encoder_top_macros.svh"
module ghe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ghe_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  ghe_out_if.source     result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  localparam int CW = ghe_pkg::CALC_W;

  state_e                       state_q, state_d;
  logic signed [CW-1:0]         lon_lo_q, lon_lo_d, lon_hi_q, lon_hi_d;
  logic signed [CW-1:0]         lat_lo_q, lat_lo_d, lat_hi_q, lat_hi_d;
  logic signed [CW-1:0]         lon_s_q, lon_s_d, lat_s_q, lat_s_d;
  logic [ghe_pkg::BITS_W-1:0]   bits_q, bits_d;
  logic [ghe_pkg::STEP_W-1:0]   step_q, step_d, nstep_q, nstep_d;
  logic [ghe_pkg::PREC_W-1:0]   prec_q, prec_d, chr_q, chr_d;
  logic                         out_valid_q, out_valid_d;
  logic [ghe_pkg::SYM_W-1:0]    out_sym_q, out_sym_d;
  logic                         out_last_q, out_last_d, out_bad_q, out_bad_d;
  logic                         can_load, take;
  logic signed [CW-1:0]         lon_mid, lat_mid;
  logic                         lon_bit, lat_bit;
  logic [ghe_pkg::NBITS_W-1:0]  nbits;

  // floor((lo + hi) / 2) without overflow
  function automatic logic signed [CW-1:0] mid_of(logic signed [CW-1:0] lo,
                                                  logic signed [CW-1:0] hi);
    logic signed [CW:0] s;
    s = {lo[CW-1], lo} + {hi[CW-1], hi};
    return s[CW:1];
  endfunction

  assign can_load    = !out_valid_q || result_o.ready;
  assign job_ready_o = (state_q == ST_IDLE) && (!job_i.bad || can_load);
  assign take        = job_valid_i && job_ready_o;

  // One longitude and one latitude halving per cycle
  assign lon_mid = mid_of(lon_lo_q, lon_hi_q);
  assign lat_mid = mid_of(lat_lo_q, lat_hi_q);
  assign lon_bit = lon_s_q > lon_mid;
  assign lat_bit = lat_s_q > lat_mid;

  assign nbits = ghe_pkg::NBITS_W'(job_i.prec) * ghe_pkg::NBITS_W'(ghe_pkg::SYM_BITS);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    lon_lo_d    = lon_lo_q;
    lon_hi_d    = lon_hi_q;
    lat_lo_d    = lat_lo_q;
    lat_hi_d    = lat_hi_q;
    lon_s_d     = lon_s_q;
    lat_s_d     = lat_s_q;
    bits_d      = bits_q;
    step_d      = step_q;
    nstep_d     = nstep_q;
    prec_d      = prec_q;
    chr_d       = chr_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;
    out_bad_d   = out_bad_q;

    unique case (state_q)
      ST_IDLE: begin
        if (take && job_i.bad) begin
          out_valid_d = 1'b1;
          out_sym_d   = '0;
          out_last_d  = 1'b1;
          out_bad_d   = 1'b1;
        end else if (take) begin
          lon_lo_d = ghe_pkg::LON_LO0;
          lon_hi_d = ghe_pkg::LON_HI0;
          lat_lo_d = ghe_pkg::LAT_LO0;
          lat_hi_d = ghe_pkg::LAT_HI0;
          lon_s_d  = {job_i.lon, ghe_pkg::EXTRA_BITS'(0)};
          lat_s_d  = {job_i.lat, ghe_pkg::EXTRA_BITS'(0)};
          bits_d   = '0;
          step_d   = '0;
          nstep_d  = ghe_pkg::STEP_W'((nbits + ghe_pkg::NBITS_W'(1)) >> 1);
          prec_d   = job_i.prec;
          state_d  = ST_CALC;
        end
      end
      ST_CALC: begin
        if (lon_bit) lon_lo_d = lon_mid;
        else         lon_hi_d = lon_mid;
        if (lat_bit) lat_lo_d = lat_mid;
        else         lat_hi_d = lat_mid;
        // bits fill from the MSB, longitude first
        for (int j = 0; j < ghe_pkg::NSTEP_MAX; j++) begin
          if (step_q == ghe_pkg::STEP_W'(j)) begin
            bits_d[ghe_pkg::BITS_W-1-2*j] = lon_bit;
            bits_d[ghe_pkg::BITS_W-2-2*j] = lat_bit;
          end
        end
        step_d = step_q + 1'b1;
        if (step_q == nstep_q - 1'b1) begin
          chr_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_sym_d   = ghe_pkg::GEO_ALPHABET[bits_q[ghe_pkg::BITS_W-1 -: ghe_pkg::SYM_BITS]];
          out_last_d  = (chr_q == prec_q - 1'b1);
          out_bad_d   = 1'b0;
          bits_d      = bits_q << ghe_pkg::SYM_BITS;
          chr_d       = chr_q + 1'b1;
          if (chr_q == prec_q - 1'b1) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    lon_lo_q   <= lon_lo_d;
    lon_hi_q   <= lon_hi_d;
    lat_lo_q   <= lat_lo_d;
    lat_hi_q   <= lat_hi_d;
    lon_s_q    <= lon_s_d;
    lat_s_q    <= lat_s_d;
    bits_q     <= bits_d;
    step_q     <= step_d;
    nstep_q    <= nstep_d;
    prec_q     <= prec_d;
    chr_q      <= chr_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_bad_q  <= out_bad_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.symbol         = out_sym_q;
  assign result_o.last           = out_last_q;
  assign result_o.bad_coordinate = out_bad_q;

  `GHE_ASSERT(a_err_form, out_valid_q && out_bad_q |-> out_last_q && (out_sym_q == '0), "error result malformed")
  `GHE_ASSERT(a_step_range, state_q == ST_CALC |-> step_q < nstep_q, "bisection ran past its step count")
  `GHE_ASSERT(a_calc_done, (state_q == ST_CALC) && (step_q == nstep_q - 1'b1) |=> (state_q == ST_EMIT) && (chr_q == '0), "bisection end not followed by emit")
  `GHE_ASSERT(a_emit_range, state_q == ST_EMIT |-> chr_q < prec_q, "character index past precision")

endmodule

[hw/rtl/geohash_encoder_top.sv]
// Geohash encoder, base32. Error item: one flagged result, registered after the queue.
// Precision P: P characters after bisection, one per cycle while receiver is ready.
// Items are encoded one at a time by the single
// bisection unit doing one longitude and one latitude halving per cycle.
// Out-of-bounds items skip the bisection. A 2-entry queue decouples input from encoding.
// Reset (rst_ni low, async) empties queue and output, restores default bounds.
`timescale 1ns / 1ps
module geohash_encoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ghe_in_if.sink                          item_i,
  ghe_out_if.source                       result_o,
  input  logic                            cfg_we_i,
  input  logic [ghe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ghe_pkg::COORD_W-1:0]     cfg_data_i
);

  ghe_pkg::cfg_wr_t cfg;
  ghe_pkg::job_t    push_job, pop_job;
  logic             push_valid, push_ready, pop_valid, pop_ready;

  // Configuration write bundle
  always_comb begin
    cfg.we   = cfg_we_i;
    cfg.idx  = ghe_pkg::cfg_idx_e'(cfg_idx_i);
    cfg.data = cfg_data_i;
  end

  ghe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  ghe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (push_job),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_data_o   (pop_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  ghe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (pop_job),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule

[sim/geohash_encoder_top_test.sv]
`timescale 1ns / 1ps
module geohash_encoder_top_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;
  // Base32 digits, first character in the top byte
  localparam logic [255:0] GH_DIGITS = "0123456789bcdefghjkmnpqrstuvwxyz";

  typedef struct {
    logic signed [ghe_pkg::COORD_W-1:0] lat;
    logic signed [ghe_pkg::COORD_W-1:0] lon;
    logic [ghe_pkg::PREC_W-1:0]         prec;
  } coord_item_t;

  typedef struct {
    logic [ghe_pkg::SYM_W-1:0] symbol;
    logic                      last;
    logic                      bad;
  } gh_char_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  ghe_pkg::cfg_idx_e cfg_idx;
  logic [ghe_pkg::COORD_W-1:0] cfg_data;

  ghe_in_if  item_if ();
  ghe_out_if result_if ();

  geohash_encoder_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Local copy of the bound registers
  logic signed [ghe_pkg::COORD_W-1:0] bound_r [4];

  coord_item_t item_q [$];
  gh_char_t    expect_q [$];
  coord_item_t offered;

  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int cycle_cnt = 0;

  always #5 clk = ~clk;

  // Random idle decision shared by both sides
  function automatic bit take_gap();
    return gaps_on && ($urandom_range(99) < 19);
  endfunction

  // Expected characters of one item under the current bounds
  function automatic void predict_geohash(coord_item_t it);
    longint lat_s, lon_s, lat_lo, lat_hi, lon_lo, lon_hi, mid;
    int nchar;
    logic [4:0] code;
    gh_char_t r;
    if (it.lat > bound_r[ghe_pkg::CFG_LAT_MAX] || it.lat < bound_r[ghe_pkg::CFG_LAT_MIN] ||
        it.lon > bound_r[ghe_pkg::CFG_LON_MAX] || it.lon < bound_r[ghe_pkg::CFG_LON_MIN]) begin
      r.symbol = '0;
      r.last = 1'b1;
      r.bad = 1'b1;
      expect_q = {expect_q, r};
      return;
    end
    nchar = (it.prec == 0 || it.prec > ghe_pkg::MAX_CHARS) ? ghe_pkg::MAX_CHARS :
            int'(it.prec);
    lat_s = longint'(it.lat) <<< ghe_pkg::EXTRA_BITS;
    lon_s = longint'(it.lon) <<< ghe_pkg::EXTRA_BITS;
    lat_hi = longint'(90) <<< (ghe_pkg::COORD_FRAC_BITS + ghe_pkg::EXTRA_BITS);
    lat_lo = -lat_hi;
    lon_hi = longint'(180) <<< (ghe_pkg::COORD_FRAC_BITS + ghe_pkg::EXTRA_BITS);
    lon_lo = -lon_hi;
    code = '0;
    for (int i = 1; i <= nchar * ghe_pkg::SYM_BITS; i++) begin
      // odd bits halve longitude, even bits latitude; midpoint rounds down
      if (i % 2 == 1) begin
        mid = (lon_lo + lon_hi) >>> 1;
        if (lon_s > mid) begin
          lon_lo = mid;
          code = {code[3:0], 1'b1};
        end else begin
          lon_hi = mid;
          code = {code[3:0], 1'b0};
        end
      end else begin
        mid = (lat_lo + lat_hi) >>> 1;
        if (lat_s > mid) begin
          lat_lo = mid;
          code = {code[3:0], 1'b1};
        end else begin
          lat_hi = mid;
          code = {code[3:0], 1'b0};
        end
      end
      if (i % ghe_pkg::SYM_BITS == 0) begin
        r.symbol = GH_DIGITS[(31 - int'(code)) * 8 +: ghe_pkg::SYM_W];
        r.last = (i == nchar * ghe_pkg::SYM_BITS);
        r.bad = 1'b0;
        expect_q = {expect_q, r};
      end
    end
  endfunction

  // Coordinate inside [lo, hi], near a bound, or anywhere
  function automatic logic signed [ghe_pkg::COORD_W-1:0] pick_coord(
      logic signed [ghe_pkg::COORD_W-1:0] lo, logic signed [ghe_pkg::COORD_W-1:0] hi,
      bit clean);
    logic [ghe_pkg::COORD_W-1:0] span;
    int unsigned pick;
    pick = clean ? 0 : $urandom_range(9);
    if (pick >= 7) return $urandom;
    if (pick == 6) return hi + $signed($urandom_range(4)) - 2;
    if (pick == 5) return lo + $signed($urandom_range(4)) - 2;
    if (hi < lo) return $urandom;
    span = hi - lo;
    return lo + $urandom_range(span);
  endfunction

  function automatic coord_item_t random_coord_item();
    coord_item_t it;
    bit clean;
    clean = $urandom_range(99) < 75;
    it.lat = pick_coord(bound_r[ghe_pkg::CFG_LAT_MIN], bound_r[ghe_pkg::CFG_LAT_MAX], clean);
    it.lon = pick_coord(bound_r[ghe_pkg::CFG_LON_MIN], bound_r[ghe_pkg::CFG_LON_MAX], clean);
    it.prec = ghe_pkg::PREC_W'($urandom_range(15));
    return it;
  endfunction

  function automatic coord_item_t mk_item(logic signed [ghe_pkg::COORD_W-1:0] lat,
                                          logic signed [ghe_pkg::COORD_W-1:0] lon,
                                          int prec);
    coord_item_t it;
    it.lat = lat;
    it.lon = lon;
    it.prec = ghe_pkg::PREC_W'(prec);
    return it;
  endfunction

  // Append one item to the pending list
  task automatic add_item(coord_item_t it);
    item_q = {item_q, it};
  endtask

  task automatic queue_random(int n);
    repeat (n) add_item(random_coord_item());
  endtask

  task automatic write_reg(ghe_pkg::cfg_idx_e idx, logic [ghe_pkg::COORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    bound_r[idx] = val;
  endtask

  task automatic put_bounds(logic [ghe_pkg::COORD_W-1:0] lat_max,
                            logic [ghe_pkg::COORD_W-1:0] lat_min,
                            logic [ghe_pkg::COORD_W-1:0] lon_max,
                            logic [ghe_pkg::COORD_W-1:0] lon_min);
    write_reg(ghe_pkg::CFG_LAT_MAX, lat_max);
    write_reg(ghe_pkg::CFG_LAT_MIN, lat_min);
    write_reg(ghe_pkg::CFG_LON_MAX, lon_max);
    write_reg(ghe_pkg::CFG_LON_MIN, lon_min);
    cfg_we <= 1'b0;
  endtask

  // Block idle: nothing queued, nothing offered, nothing outstanding.
  // Checked at the falling edge so the driver's updates have settled.
  task automatic wait_drained();
    @(negedge clk);
    while (!(item_q.size() == 0 && !item_if.valid && expect_q.size() == 0))
      @(negedge clk);
    @(posedge clk);
  endtask

  // Input driver: holds an item until its transfer
  always @(posedge clk or negedge rst_n) begin : item_driver
    if (!rst_n) begin
      item_if.valid <= 1'b0;
      item_if.latitude <= '0;
      item_if.longitude <= '0;
      item_if.precision <= '0;
    end else if (!item_if.valid || item_if.ready) begin
      if (item_if.valid) predict_geohash(offered);
      if (item_q.size() != 0 && !take_gap()) begin
        offered = item_q.pop_front();
        item_if.valid <= 1'b1;
        item_if.latitude <= offered.lat;
        item_if.longitude <= offered.lon;
        item_if.precision <= offered.prec;
      end else begin
        item_if.valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk or negedge rst_n) begin : result_monitor
    gh_char_t want;
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expect_q.size() == 0) begin
          $error("unexpected result: symbol %0h last %0b bad_coordinate %0b",
                 result_if.symbol, result_if.last, result_if.bad_coordinate);
          errors++;
        end else begin
          want = expect_q.pop_front();
          if (result_if.symbol !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, result_if.symbol);
            errors++;
          end
          if (result_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, result_if.last);
            errors++;
          end
          if (result_if.bad_coordinate !== want.bad) begin
            $error("bad_coordinate: expected %0b, got %0b", want.bad,
                   result_if.bad_coordinate);
            errors++;
          end
        end
      end
      // one long hold-off on request, random gaps otherwise
      if (hold_left > 0) begin
        result_if.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_used) begin
        result_if.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_used <= 1'b1;
      end else begin
        result_if.ready <= !take_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("geohash_encoder_top_test failed");
      $finish;
    end
  end

  initial begin
    cfg_we <= 1'b0;
    cfg_idx <= ghe_pkg::CFG_LAT_MAX;
    cfg_data <= '0;
    rst_n <= 1'b0;
    bound_r[ghe_pkg::CFG_LAT_MAX] = ghe_pkg::LAT_MAX_RST;
    bound_r[ghe_pkg::CFG_LAT_MIN] = ghe_pkg::LAT_MIN_RST;
    bound_r[ghe_pkg::CFG_LON_MAX] = ghe_pkg::LON_MAX_RST;
    bound_r[ghe_pkg::CFG_LON_MIN] = ghe_pkg::LON_MIN_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under reset bounds
    add_item(mk_item(0, 0, 0));                       // exact midpoints, precision 0
    add_item(mk_item(0, 0, 1));
    // inclusive upper and lower bounds
    add_item(mk_item(ghe_pkg::LAT_MAX_RST, ghe_pkg::LON_MAX_RST, 12));
    add_item(mk_item(ghe_pkg::LAT_MIN_RST, ghe_pkg::LON_MIN_RST, 12));
    add_item(mk_item(ghe_pkg::LAT_MAX_RST + 1, 0, 12));
    add_item(mk_item(ghe_pkg::LAT_MIN_RST - 1, 0, 3));
    add_item(mk_item(0, ghe_pkg::LON_MAX_RST + 1, 7));
    add_item(mk_item(0, ghe_pkg::LON_MIN_RST - 1, 12));
    add_item(mk_item(32'sh7fffffff, 32'sh80000000, 4));
    add_item(mk_item(-1, -1, 13));
    add_item(mk_item(1, 1, 14));
    add_item(mk_item(-32'sd100000000, 32'sd900000000, 15));
    add_item(mk_item(32'sd45 <<< ghe_pkg::COORD_FRAC_BITS,
                     32'sd90 <<< ghe_pkg::COORD_FRAC_BITS, 12));
    for (int p = 2; p <= 11; p++)
      add_item(mk_item(32'sd483595805, 32'sd87303935, p));
    wait_drained();

    // Random, reset bounds
    queue_random(80);
    wait_drained();

    // Stretch without idling on either side
    gaps_on <= 1'b0;
    queue_random(40);
    wait_drained();
    gaps_on <= 1'b1;

    // Receiver holds off while the sender keeps offering
    queue_random(30);
    hold_req <= 1'b1;
    wait_drained();

    // Widest bounds: out-of-range coordinates saturate
    put_bounds(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_item(mk_item(32'sh7fffffff, 32'sh7fffffff, 12));
    add_item(mk_item(32'sh80000000, 32'sh80000000, 12));
    add_item(mk_item(ghe_pkg::LAT_MAX_RST + 1, ghe_pkg::LON_MIN_RST - 1, 5));
    queue_random(40);
    wait_drained();

    // Random ordered bounds
    repeat (2) begin
      logic signed [ghe_pkg::COORD_W-1:0] a, b, c, d;
      a = $urandom;
      b = $urandom;
      c = $urandom;
      d = $urandom;
      put_bounds((a > b) ? a : b, (a > b) ? b : a, (c > d) ? c : d, (c > d) ? d : c);
      queue_random(20);
      wait_drained();
    end

    // Minimum above maximum on latitude, then on longitude
    put_bounds(0, 1, ghe_pkg::LON_MAX_RST, ghe_pkg::LON_MIN_RST);
    add_item(mk_item(0, 0, 12));
    add_item(mk_item(1, 0, 12));
    queue_random(3);
    wait_drained();
    put_bounds(ghe_pkg::LAT_MAX_RST, ghe_pkg::LAT_MIN_RST, -32'sd5, 32'sd5);
    add_item(mk_item(0, 0, 12));
    add_item(mk_item(0, 5, 1));
    queue_random(3);
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("geohash_encoder_top_test passed");
    end else begin
      $display("geohash_encoder_top_test failed");
    end
    $finish;
  end

endmodule
